@@ rtl/isru_pkg.sv @@
// ----------------------------------------------------------------------------
// isru_pkg
// Shared widths and types for the inverse square-root unit activation.
// ----------------------------------------------------------------------------
package isru_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 12;
    localparam int ALPHA_W      = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(4096);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // magnitude reaches 2^(SAMPLE_WIDTH-1)
    localparam int MAG_W  = SAMPLE_WIDTH;
    localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1;
    localparam int PROD_W = SQ_W + ALPHA_W;
    localparam int SUM_W  = imax(PROD_W + FRAC_BITS, 4 * FRAC_BITS + 1) + 1;
    localparam int RAD_W  = SUM_W + (SUM_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int NUM_W  = imax(MAG_W + 2 * FRAC_BITS + 1, ROOT_W) + 1;
    localparam int DIV_W  = ROOT_W + 1;
    localparam int Q_W    = MAG_W;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             last;
    } side_t;

endpackage

@@ rtl/isru_sqrt.sv @@
// ----------------------------------------------------------------------------
// isru_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module isru_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [isru_pkg::RAD_W-1:0]  rad,
    input  isru_pkg::side_t        in_side,
    output logic                   out_valid,
    output logic [isru_pkg::ROOT_W-1:0] root,
    output isru_pkg::side_t        out_side
);
    import isru_pkg::*;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    side_t             side_reg [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic              vld_in;
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            side_t             side_in;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              ge;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;
            logic [RAD_W-1:0]  rad_next;

            if (k == 0) begin : g_first
                assign vld_in  = in_valid;
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = in_side;
            end
            else begin : g_rest
                assign vld_in  = vld_reg[k-1];
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // one digit of the restoring root
            assign rem_sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
            assign trial     = {root_in, 2'b01};
            assign ge        = (rem_sh >= trial);
            assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
            assign root_next = {root_in[ROOT_W-2:0], ge};
            assign rad_next  = {rad_in[RAD_W-3:0], 2'b00};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= rad_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

@@ rtl/isru_div.sv @@
// ----------------------------------------------------------------------------
// isru_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module isru_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [isru_pkg::NUM_W-1:0] num,
    input  logic [isru_pkg::DIV_W-1:0] den,
    input  isru_pkg::side_t            in_side,
    output logic                       out_valid,
    output logic [isru_pkg::Q_W-1:0]   quo,
    output isru_pkg::side_t            out_side
);
    import isru_pkg::*;

    logic             vld_reg  [Q_W];
    logic [DIV_W-1:0] rem_reg  [Q_W];
    logic [DIV_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   nlo_reg  [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];
    side_t            side_reg [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic             vld_in;
            logic [DIV_W-1:0] rem_in;
            logic [DIV_W-1:0] den_in;
            logic [Q_W-1:0]   nlo_in;
            logic [Q_W-1:0]   quo_in;
            side_t            side_in;
            logic [DIV_W:0]   rem_sh;
            logic [DIV_W:0]   diff;
            logic             ge;
            logic [DIV_W-1:0] rem_next;
            logic [Q_W-1:0]   nlo_next;
            logic [Q_W-1:0]   quo_next;

            if (k == 0) begin : g_first
                // quotient fits Q_W bits, so the upper part is below den
                assign vld_in  = in_valid;
                assign rem_in  = DIV_W'(num >> Q_W);
                assign den_in  = den;
                assign nlo_in  = num[Q_W-1:0];
                assign quo_in  = '0;
                assign side_in = in_side;
            end
            else begin : g_rest
                assign vld_in  = vld_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign nlo_in  = nlo_reg[k-1];
                assign quo_in  = quo_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            assign rem_sh   = {rem_in, nlo_in[Q_W-1]};
            assign ge       = (rem_sh >= {1'b0, den_in});
            assign diff     = rem_sh - {1'b0, den_in};
            assign rem_next = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            assign nlo_next = {nlo_in[Q_W-2:0], 1'b0};
            assign quo_next = {quo_in[Q_W-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_in;
                    nlo_reg[k]  <= nlo_next;
                    quo_reg[k]  <= quo_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

@@ rtl/isru_activation.sv @@
// ----------------------------------------------------------------------------
// isru_activation
// Inverse square-root unit activation y = x / sqrt(1 + alpha*x*x), Q4.12.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one signed Q4.12 sample per transfer in tdata, with
//   tlast marking the end of a vector. m_axis returns the rounded result
//   in tdata and the copied tlast, one transfer per input transfer, in order.
//   cfg_we/cfg_wdata write alpha (unsigned Q4.12); write it only while no
//   transfer is in flight.
// throughput and pipeline
//   one transfer per clock cycle sustained while m_axis is not stalled. an
//   input transfer passes the magnitude, square, alpha product and sum
//   registers, 30 root stages (one bit per stage), the setup register, 16
//   divider stages (one quotient bit per stage) and the output register.
// reset
//   rst_n clears every valid bit and sets alpha to 1.0 (4096).
// stall
//   when m_axis holds a result that is not taken, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module isru_activation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [isru_pkg::ALPHA_W-1:0]  cfg_wdata,     // alpha
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [isru_pkg::TDATA_W-1:0]  s_axis_tdata,  // x
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [isru_pkg::TDATA_W-1:0]  m_axis_tdata,  // y
    output logic                          m_axis_tlast
);
    import isru_pkg::*;

    logic                     adv;
    logic [ALPHA_W-1:0]       alpha_reg;

    logic                     v0_reg;
    side_t                    side0_reg;
    side_t                    side0_next;
    logic [SAMPLE_WIDTH-1:0]  x_in;

    logic                     v1_reg;
    side_t                    side1_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [2*MAG_W-1:0]       sq_full;

    logic                     v2_reg;
    side_t                    side2_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        prod_next;

    logic                     v3_reg;
    side_t                    side3_reg;
    logic [RAD_W-1:0]         sum_reg;
    logic [RAD_W-1:0]         sum_next;

    logic                     sq_valid;
    logic [ROOT_W-1:0]        root;
    side_t                    sq_side;

    logic                     v4_reg;
    side_t                    side4_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [NUM_W-1:0]         num_next;
    logic [DIV_W-1:0]         den_reg;

    logic                     dv_valid;
    logic [Q_W-1:0]           quo;
    side_t                    dv_side;
    logic [Q_W-1:0]           quo_clamp;

    logic                     out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]  y_reg;
    logic [SAMPLE_WIDTH-1:0]  y_next;
    logic                     last_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            alpha_reg <= cfg_wdata;
        end
    end

    // stage 0: sign and magnitude
    assign x_in = s_axis_tdata[SAMPLE_WIDTH-1:0];

    always_comb
    begin
        side0_next.neg  = x_in[SAMPLE_WIDTH-1];
        side0_next.mag  = x_in[SAMPLE_WIDTH-1] ? (~x_in + 1'b1) : x_in;
        side0_next.last = s_axis_tlast;
    end

    // stage 1 to 3: square, alpha product, radicand
    assign sq_full   = side0_reg.mag * side0_reg.mag;
    assign prod_next = alpha_reg * sq_reg;

    always_comb
    begin
        sum_next = (RAD_W'(1) << (4 * FRAC_BITS)) + (RAD_W'(prod_reg) << FRAC_BITS);
    end

    // stage 4: divider operands, num = mag*2^(2F+1) + root, den = 2*root
    always_comb
    begin
        num_next = (NUM_W'(sq_side.mag) << (2 * FRAC_BITS + 1)) + NUM_W'(root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side0_reg <= side0_next;
            side1_reg <= side0_reg;
            sq_reg    <= sq_full[SQ_W-1:0];
            side2_reg <= side1_reg;
            prod_reg  <= prod_next;
            side3_reg <= side2_reg;
            sum_reg   <= sum_next;
            side4_reg <= sq_side;
            num_reg   <= num_next;
            den_reg   <= {root, 1'b0};
        end
    end

    isru_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .rad       (sum_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .root      (root),
        .out_side  (sq_side)
    );

    isru_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .num       (num_reg),
        .den       (den_reg),
        .in_side   (side4_reg),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_side  (dv_side)
    );

    // output register: clamp and restore sign
    assign quo_clamp = (quo > dv_side.mag) ? dv_side.mag : quo;
    assign y_next    = dv_side.neg ? SAMPLE_WIDTH'(~quo_clamp + 1'b1)
                                   : SAMPLE_WIDTH'(quo_clamp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg    <= y_next;
            last_reg <= dv_side.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(y_reg);
    assign m_axis_tlast  = last_reg;

endmodule
